// ===== hdl/lei_pkg.sv =====
// shared types and constants for the line edit input buffer
// depends on nothing; every other file of the block imports it
package lei_pkg;

	// control bytes with a meaning to the line discipline
	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CTRL_H = 8'h08;
	localparam logic [7:0] KEY_LF     = 8'h0A;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_CTRL_P = 8'h10;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_DEL    = 8'h7F;
	localparam logic [7:0] ERASE_MAX  = 8'hFF;

	// item operation codes
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic       first_of_read;
	} in_item_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic [7:0] erase_count;
		logic       line_ready;
		logic       dump_request;
		logic       dropped;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       read_done;
		logic       buffer_empty;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} lei_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic byte_go;
		logic read_go;
		logic read_finish;
	} lei_cmd_t;

endpackage

// ===== hdl/lei_in_if.sv =====
// input item channel: valid, ready and one input item
// depends on lei_pkg
interface lei_in_if;
	import lei_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/lei_out_if.sv =====
// result item channel: valid, ready and one result item
// depends on lei_pkg
interface lei_out_if;
	import lei_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/line_edit_input_buffer.sv =====
// top level of the canonical-mode line edit input buffer
// depends on lei_pkg, lei_in_if, lei_out_if, lei_ctrl and lei_dpath
//
//   channel   role     payload
//   item      sink     op, rx_byte, first_of_read
//   result    source   echo/erase/commit flags and the delivered read byte
//
// a received byte has its result registered at acceptance
// a read item goes through the line store read, then the decode
// the rate is set by the single-ported line store and its registered read
// a new item is taken while a result waits, if that result leaves the same cycle
// reset clears the three indices; the line store needs no clearing
module line_edit_input_buffer #(
	parameter int BUF_DEPTH = 128
) (
	input logic       clk,
	input logic       arst_n,
	lei_in_if.sink    item,
	lei_out_if.source result
);
	import lei_pkg::*;

	lei_cmd_t cmd;

	lei_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_op     (item.data.op),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	lei_dpath #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rx_byte       (item.data.rx_byte),
		.first_of_read (item.data.first_of_read),
		.res           (result.data)
	);
endmodule

// ===== hdl/lei_ctrl.sv =====
// controller: accepts items, sequences the buffer read, owns result valid
// depends on lei_pkg
module lei_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output lei_pkg::lei_cmd_t cmd
);
	import lei_pkg::*;

	lei_state_t state_q;
	lei_state_t state_d;
	logic       out_valid_q;
	logic       accept;

	// result slot is free, or is emptied by this very transfer
	assign accept = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (in_op == OP_READ)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = !out_valid_q || out_ready;
				cmd.byte_go = accept && (in_op == OP_RX);
				cmd.read_go = accept && (in_op == OP_READ);
			end
			ST_READ: cmd.read_finish = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.byte_go || cmd.read_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== hdl/lei_dpath.sv =====
// datapath: line store memory, read/commit/edit indices, result register
// depends on lei_pkg
module lei_dpath #(
	parameter int BUF_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lei_pkg::lei_cmd_t  cmd,
	input  logic [7:0]         rx_byte,
	input  logic               first_of_read,
	output lei_pkg::out_item_t res
);
	import lei_pkg::*;

	localparam int IW = $clog2(2 * BUF_DEPTH);
	localparam int SW = $clog2(BUF_DEPTH);
	localparam int EW = (IW > 8) ? IW : 8;
	localparam logic [IW-1:0] DEPTH_I = IW'(BUF_DEPTH);
	localparam logic [IW-1:0] LAST_I  = IW'(2 * BUF_DEPTH - 1);
	localparam logic [IW-1:0] MOD_I   = IW'(2 * BUF_DEPTH);

	// index arithmetic modulo twice the depth
	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
		return (a == LAST_I) ? '0 : a + IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
		return (a == '0) ? LAST_I : a - IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] hi,
			input logic [IW-1:0] lo);
		return (hi < lo) ? hi - lo + MOD_I : hi - lo;
	endfunction

	function automatic logic [SW-1:0] idx_slot(input logic [IW-1:0] a);
		logic [IW-1:0] r;
		r = (a >= DEPTH_I) ? a - DEPTH_I : a;
		return r[SW-1:0];
	endfunction

	logic [7:0]    store_mem [BUF_DEPTH];
	logic [IW-1:0] read_q, commit_q, edit_q;
	logic [IW-1:0] read_d, commit_d, edit_d;
	logic [IW-1:0] edit_inc, read_inc, fill, line_len;
	logic [EW-1:0] line_len_w;
	logic [7:0]    erase_all;
	logic [7:0]    stored_byte;
	logic [7:0]    rdata_q;
	logic          first_q;
	logic          wr_en;
	out_item_t     res_d;
	out_item_t     res_q;

	assign edit_inc    = idx_inc(edit_q);
	assign read_inc    = idx_inc(read_q);
	assign fill        = idx_dist(edit_q, read_q);
	assign line_len    = idx_dist(edit_q, commit_q);
	assign line_len_w  = EW'(line_len);
	assign erase_all   = (line_len_w > EW'(ERASE_MAX)) ? ERASE_MAX : line_len_w[7:0];
	assign stored_byte = (rx_byte == KEY_CR) ? KEY_LF : rx_byte;

	// item decode and index update
	always_comb begin
		read_d   = read_q;
		commit_d = commit_q;
		edit_d   = edit_q;
		wr_en    = 1'b0;
		res_d    = '0;
		if (cmd.byte_go) begin
			case (rx_byte)
				KEY_CTRL_P: res_d.dump_request = 1'b1;
				KEY_CTRL_U: begin
					edit_d            = commit_q;
					res_d.erase_count = erase_all;
				end
				KEY_CTRL_H, KEY_DEL: begin
					if (edit_q != commit_q) begin
						edit_d            = idx_dec(edit_q);
						res_d.erase_count = 8'd1;
					end
				end
				KEY_NUL: begin
				end
				default: begin
					if (fill < DEPTH_I) begin
						wr_en            = 1'b1;
						edit_d           = edit_inc;
						res_d.echo_valid = 1'b1;
						res_d.echo_byte  = stored_byte;
						// newline, end of file or a ring that is now full
						if (stored_byte == KEY_LF || stored_byte == KEY_CTRL_D ||
								fill == DEPTH_I - IW'(1)) begin
							commit_d         = edit_inc;
							res_d.line_ready = 1'b1;
						end
					end else begin
						res_d.dropped = 1'b1;
					end
				end
			endcase
		end else if (cmd.read_finish) begin
			if (read_q == commit_q) begin
				res_d.buffer_empty = 1'b1;
			end else if (rdata_q == KEY_CTRL_D) begin
				// end of file stays put when bytes went out earlier in this read
				if (first_q) begin
					read_d = read_inc;
				end
				res_d.read_done = 1'b1;
			end else begin
				read_d           = read_inc;
				res_d.read_valid = 1'b1;
				res_d.read_byte  = rdata_q;
				res_d.read_done  = (rdata_q == KEY_LF);
			end
		end
	end

	// line store, single port: write on a stored byte, read on a read item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[idx_slot(edit_q)] <= stored_byte;
		end
		if (cmd.read_go) begin
			rdata_q <= store_mem[idx_slot(read_q)];
			first_q <= first_of_read;
		end
	end

	// indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q   <= '0;
			commit_q <= '0;
			edit_q   <= '0;
		end else begin
			read_q   <= read_d;
			commit_q <= commit_d;
			edit_q   <= edit_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.byte_go || cmd.read_finish) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;
endmodule

// ===== tb/tb_line_edit_input_buffer.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the canonical-mode line edit input buffer
// depends on lei_pkg, lei_in_if, lei_out_if and line_edit_input_buffer
module tb_line_edit_input_buffer;
	import lei_pkg::*;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = $clog2(2 * DEPTH);
	localparam int SLOT_W = $clog2(DEPTH);

	// keeps its own copy of the ring and indices, queues the predicted results
	class line_edit_scoreboard;
		logic [7:0]       ring [DEPTH];
		logic [IDX_W-1:0] rd_idx;
		logic [IDX_W-1:0] cm_idx;
		logic [IDX_W-1:0] ed_idx;
		out_item_t        results_due [$];
		int               errors;

		function new();
			rd_idx = '0;
			cm_idx = '0;
			ed_idx = '0;
			errors = 0;
		endfunction

		function logic [IDX_W-1:0] span(logic [IDX_W-1:0] hi, logic [IDX_W-1:0] lo);
			return hi - lo;
		endfunction

		// work out the result of one accepted input transfer
		function out_item_t take_item(in_item_t it);
			out_item_t        r;
			logic [7:0]       c;
			logic [IDX_W-1:0] n;
			r = '0;
			c = it.rx_byte;
			if (it.op == OP_RX) begin
				if (c == KEY_CTRL_P) begin
					r.dump_request = 1'b1;
				end else if (c == KEY_CTRL_U) begin
					n = span(ed_idx, cm_idx);
					ed_idx = cm_idx;
					r.erase_count = (n > ERASE_MAX) ? ERASE_MAX : 8'(n);
				end else if (c == KEY_CTRL_H || c == KEY_DEL) begin
					if (ed_idx != cm_idx) begin
						ed_idx = ed_idx - 1'b1;
						r.erase_count = 8'd1;
					end
				end else if (c != KEY_NUL) begin
					if (span(ed_idx, rd_idx) < DEPTH) begin
						if (c == KEY_CR)
							c = KEY_LF;
						ring[ed_idx[SLOT_W-1:0]] = c;
						ed_idx = ed_idx + 1'b1;
						r.echo_valid = 1'b1;
						r.echo_byte = c;
						if (c == KEY_LF || c == KEY_CTRL_D || span(ed_idx, rd_idx) == DEPTH) begin
							cm_idx = ed_idx;
							r.line_ready = 1'b1;
						end
					end else begin
						r.dropped = 1'b1;
					end
				end
			end else begin
				if (rd_idx == cm_idx) begin
					r.buffer_empty = 1'b1;
				end else begin
					c = ring[rd_idx[SLOT_W-1:0]];
					if (c == KEY_CTRL_D) begin
						// end of file after earlier bytes stays for the next read
						if (it.first_of_read)
							rd_idx = rd_idx + 1'b1;
						r.read_done = 1'b1;
					end else begin
						rd_idx = rd_idx + 1'b1;
						r.read_valid = 1'b1;
						r.read_byte = c;
						r.read_done = (c == KEY_LF);
					end
				end
			end
			results_due.push_back(r);
			return r;
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		// compare one result transfer with the oldest prediction
		task check_result(out_item_t got);
			out_item_t want;
			if (results_due.size() == 0) begin
				report("result transfer with nothing due");
				return;
			end
			want = results_due.pop_front();
			compare_field("echo_valid", got.echo_valid, want.echo_valid);
			compare_field("echo_byte", got.echo_byte, want.echo_byte);
			compare_field("erase_count", got.erase_count, want.erase_count);
			compare_field("line_ready", got.line_ready, want.line_ready);
			compare_field("dump_request", got.dump_request, want.dump_request);
			compare_field("dropped", got.dropped, want.dropped);
			compare_field("read_valid", got.read_valid, want.read_valid);
			compare_field("read_byte", got.read_byte, want.read_byte);
			compare_field("read_done", got.read_done, want.read_done);
			compare_field("buffer_empty", got.buffer_empty, want.buffer_empty);
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   first_flag;
	int   read_pct;

	lei_in_if  item_ch ();
	lei_out_if result_ch ();

	line_edit_scoreboard sb = new();

	line_edit_input_buffer #(
		.BUF_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// result side back-pressure
	always @(posedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 14);
	end

	// check every result transfer
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_result(result_ch.data);
	end

	function in_item_t rx(logic [7:0] b);
		in_item_t it;
		it.op = OP_RX;
		it.rx_byte = b;
		it.first_of_read = 1'($urandom_range(1));
		return it;
	endfunction

	// reader follows its own request boundaries, now and then a stray flag
	function in_item_t rd();
		in_item_t it;
		it.op = OP_READ;
		it.rx_byte = 8'($urandom_range(255));
		it.first_of_read = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : first_flag;
		return it;
	endfunction

	// editing keys often, any byte otherwise
	function logic [7:0] pick_byte();
		int roll;
		roll = $urandom_range(99);
		if (roll < 6)  return KEY_LF;
		if (roll < 9)  return KEY_CR;
		if (roll < 12) return KEY_CTRL_D;
		if (roll < 15) return KEY_CTRL_H;
		if (roll < 18) return KEY_DEL;
		if (roll < 20) return KEY_CTRL_U;
		if (roll < 22) return KEY_CTRL_P;
		if (roll < 24) return KEY_NUL;
		return 8'($urandom_range(255));
	endfunction

	// one input transfer, with a random gap in front
	task send_item(in_item_t it);
		int        gap;
		out_item_t p;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 14)
				gap++;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		p = sb.take_item(it);
		if (it.op == OP_READ) begin
			if (p.read_done)
				first_flag = 1'b1;
			else if (p.read_valid)
				first_flag = 1'b0;
		end
	endtask

	initial begin
		int i;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		calm = 1'b0;
		first_flag = 1'b1;
		read_pct = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty reads, ignored and editing keys on an empty line
		send_item(rd());
		send_item(rx(KEY_NUL));
		send_item(rx(KEY_CTRL_P));
		send_item(rx(KEY_CTRL_U));
		send_item(rx(KEY_CTRL_H));
		send_item(rx(KEY_DEL));
		// directed: edit a line then kill it
		send_item(rx(8'h61));
		send_item(rx(8'hFF));
		send_item(rx(KEY_DEL));
		send_item(rx(8'h62));
		send_item(rx(KEY_CTRL_H));
		send_item(rx(8'h63));
		send_item(rx(8'h64));
		send_item(rx(KEY_CTRL_U));
		// directed: carriage return commits as newline
		send_item(rx(8'h78));
		send_item(rx(KEY_CR));
		send_item(rd());
		send_item(rd());
		// directed: end of file after a byte is held for the next read
		send_item(rx(8'h79));
		send_item(rx(KEY_CTRL_D));
		send_item(rd());
		send_item(rd());
		send_item(rd());
		send_item(rd());

		// random phases of typing and reading, some filling the ring
		for (i = 0; i < 2000; i++) begin
			if (i % 250 == 0) begin
				case ($urandom_range(3))
					0: read_pct = 5;
					1: read_pct = 30;
					2: read_pct = 50;
					default: read_pct = 90;
				endcase
			end
			calm = (i >= 900 && i < 1300);
			if ($urandom_range(99) < read_pct)
				send_item(rd());
			else
				send_item(rx(pick_byte()));
		end
		calm = 1'b0;
		item_ch.valid <= 1'b0;

		// drain
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
